/* rtl/coa_pkg.sv */
package coa_pkg;
	localparam int STATE_W = 50;
	localparam int SITE_W = 5;
	localparam int SIDE_W = 3;

	typedef struct packed {
		logic start;
		logic load_tort;
		logic step_hare;
		logic load_scan;
		logic step_scan;
		logic div_start;
	} coa_cmd_t;

	typedef struct packed {
		logic match;
		logic lam_at_limit;
		logic power_eq_lam;
		logic scan_done;
		logic div_done;
	} coa_sts_t;

	function automatic logic [STATE_W-1:0] coa_advance(input logic [STATE_W-1:0] s,
		input logic [SIDE_W-1:0] l);
		logic [STATE_W-1:0] r;
		int xr, xl, yu, yd, i;
		r = '0;
		for (int y = 0; y < 5; y++) begin
			for (int x = 0; x < 5; x++) begin
				if (x < int'(l) && y < int'(l)) begin
					i = x + int'(l) * y;
					xr = (x + 1 == int'(l)) ? 0 : x + 1;
					xl = (x == 0) ? int'(l) - 1 : x - 1;
					yu = (y + 1 == int'(l)) ? 0 : y + 1;
					yd = (y == 0) ? int'(l) - 1 : y - 1;
					r[2*i] = s[2*(xr + int'(l)*y)] ^ s[2*(xl + int'(l)*y)]
						^ s[2*(x + int'(l)*yu)] ^ s[2*(x + int'(l)*yd)] ^ s[2*i+1];
					r[2*i+1] = s[2*i];
				end
			end
		end
		return r;
	endfunction
endpackage

/* rtl/coa_if.sv */
interface coa_in_if;
	logic valid;
	logic ready;
	logic [49:0] initial_state;
	modport source(output valid, initial_state, input ready);
	modport sink(input valid, initial_state, output ready);
endinterface

interface coa_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] average_q30;
	logic signed [32:0] product_sum;
	logic [31:0] orbit_length;
	logic timed_out;
	modport source(output valid, average_q30, product_sum, orbit_length, timed_out,
		input ready);
	modport sink(input valid, average_q30, product_sum, orbit_length, timed_out,
		output ready);
endinterface

/* rtl/coa_datapath.sv */
module coa_datapath #(
	parameter int COUNT_WIDTH = 32
) (
	input logic clk,
	input coa_pkg::coa_cmd_t cmd,
	output coa_pkg::coa_sts_t sts,
	input logic [49:0] initial_state,
	input logic [2:0] lattice_side,
	input logic [31:0] iteration_limit,
	input logic [4:0] first_site,
	input logic [4:0] second_site,
	output logic signed [31:0] average_q30,
	output logic signed [32:0] product_sum,
	output logic [31:0] orbit_length
);
	import coa_pkg::*;
	localparam int DW = COUNT_WIDTH + 31;

	logic [2:0] side;
	logic [5:0] n;
	logic [49:0] mask;
	logic [STATE_W-1:0] s0_q, tort_q, hare_q, scan_q;
	logic [COUNT_WIDTH-1:0] lam_q, power_q, limit_q, cnt_q;
	logic [SITE_W-1:0] a_q, b_q;
	logic [2:0] l_q;
	logic signed [COUNT_WIDTH:0] sum_q;
	logic [DW-1:0] rem_q, quo_q;
	logic [6:0] div_cnt_q;
	logic [COUNT_WIDTH+1:0] trial;
	logic [5:0] fa, fb;

	always_comb begin
		side = lattice_side < 3'd2 ? 3'd2 : (lattice_side > 3'd5 ? 3'd5 : lattice_side);
		n = 6'(side) * 6'(side);
		mask = (50'd1 << (2 * n)) - 50'd1;
		fa = {1'b0, first_site};
		fb = {1'b0, second_site};
		for (int k = 0; k < 8; k++) begin
			if (fa >= n) fa = fa - n;
			if (fb >= n) fb = fb - n;
		end
	end

	assign trial = {1'b0, rem_q[COUNT_WIDTH-1:0], quo_q[DW-1]} - {2'b00, lam_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			l_q <= side;
			s0_q <= initial_state & mask;
			tort_q <= initial_state & mask;
			hare_q <= coa_advance(initial_state & mask, side);
			lam_q <= COUNT_WIDTH'(1);
			power_q <= COUNT_WIDTH'(1);
			limit_q <= COUNT_WIDTH >= 32 ? COUNT_WIDTH'(iteration_limit)
				: ((|(iteration_limit >> COUNT_WIDTH)) ? '1 : COUNT_WIDTH'(iteration_limit));
			a_q <= SITE_W'(fa);
			b_q <= SITE_W'(fb);
		end
		if (cmd.step_hare) begin
			if (cmd.load_tort) begin
				tort_q <= hare_q;
				power_q <= power_q << 1;
				lam_q <= COUNT_WIDTH'(1);
			end else
				lam_q <= lam_q + 1'b1;
			hare_q <= coa_advance(hare_q, l_q);
		end
		if (cmd.load_scan) begin
			scan_q <= s0_q;
			cnt_q <= '0;
			sum_q <= '0;
		end
		if (cmd.step_scan) begin
			sum_q <= (scan_q[2*a_q] == scan_q[2*b_q]) ? sum_q + 1'b1 : sum_q - 1'b1;
			scan_q <= coa_advance(scan_q, l_q);
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= DW'(sum_q[COUNT_WIDTH] ? -sum_q : sum_q) << 30;
			div_cnt_q <= '0;
		end else if (div_cnt_q != 7'(DW)) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (!trial[COUNT_WIDTH+1]) begin
				rem_q <= DW'(trial[COUNT_WIDTH-1:0]);
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign sts.match = tort_q == hare_q && lam_q <= limit_q;
	assign sts.lam_at_limit = lam_q >= limit_q;
	assign sts.power_eq_lam = power_q == lam_q;
	assign sts.scan_done = cnt_q == lam_q;
	assign sts.div_done = div_cnt_q == 7'(DW);
	assign product_sum = 33'(sum_q);
	assign orbit_length = 32'(lam_q);
	assign average_q30 = sum_q[COUNT_WIDTH] ? -32'(quo_q) : 32'(quo_q);
endmodule

/* rtl/coa_ctrl.sv */
module coa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output logic timed_out,
	output coa_pkg::coa_cmd_t cmd,
	input coa_pkg::coa_sts_t sts
);
	import coa_pkg::*;
	typedef enum logic [2:0] {IDLE, SEARCH, SCAN, DIVW, DIV, DONE} st_t;
	st_t st_q;

	assign in_ready = st_q == IDLE;
	assign out_valid = st_q == DONE;

	always_comb begin
		cmd = '0;
		cmd.start = in_valid && st_q == IDLE;
		cmd.step_hare = st_q == SEARCH && !sts.match && !sts.lam_at_limit;
		cmd.load_tort = cmd.step_hare && sts.power_eq_lam;
		cmd.load_scan = st_q == SEARCH && sts.match;
		cmd.step_scan = st_q == SCAN && !sts.scan_done;
		cmd.div_start = st_q == SCAN && sts.scan_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			timed_out <= 1'b0;
		end else begin
			unique case (st_q)
				IDLE: if (in_valid) st_q <= SEARCH;
				SEARCH: begin
					if (sts.match) begin
						timed_out <= 1'b0;
						st_q <= SCAN;
					end else if (sts.lam_at_limit) begin
						timed_out <= 1'b1;
						st_q <= DONE;
					end
				end
				SCAN: if (sts.scan_done) st_q <= DIVW;
				DIVW: st_q <= DIV;
				DIV: if (sts.div_done) st_q <= DONE;
				DONE: if (out_ready) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> st_q == SEARCH) else $error("start lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step_hare && cmd.step_scan)) else $error("phase overlap");
`endif
endmodule

/* rtl/ca_orbit_correlation_average.sv */
// One item runs Brent's cycle search, one automaton step per cycle, then a scan over
// one orbit, then a restoring divider of COUNT_WIDTH+31 steps (63 at the default width).
// The search times out when the step count since the last tortoise move reaches
// iteration_limit without a match.
module ca_orbit_correlation_average #(
	parameter int COUNT_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	coa_in_if.sink in_ch,
	coa_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import coa_pkg::*;
	localparam logic [1:0] R_SIDE = 2'd0, R_LIMIT = 2'd1, R_A = 2'd2, R_B = 2'd3;
	logic [2:0] side_q;
	logic [31:0] limit_q;
	logic [4:0] a_q, b_q;
	logic to;
	logic signed [31:0] avg;
	logic signed [32:0] psum;
	logic [31:0] olen;
	coa_cmd_t cmd;
	coa_sts_t sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 3'd4;
			limit_q <= 32'd100000000;
			a_q <= 5'd0;
			b_q <= 5'd12;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				R_SIDE: side_q <= pwdata[2:0];
				R_LIMIT: limit_q <= pwdata;
				R_A: a_q <= pwdata[4:0];
				R_B: b_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			R_SIDE: prdata = {29'd0, side_q};
			R_LIMIT: prdata = limit_q;
			R_A: prdata = {27'd0, a_q};
			default: prdata = {27'd0, b_q};
		endcase
	end

	coa_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .timed_out(to), .cmd, .sts);
	coa_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (.clk, .cmd, .sts,
		.initial_state(in_ch.initial_state), .lattice_side(side_q),
		.iteration_limit(limit_q), .first_site(a_q), .second_site(b_q),
		.average_q30(avg), .product_sum(psum), .orbit_length(olen));

	assign out_ch.timed_out = to;
	assign out_ch.average_q30 = to ? '0 : avg;
	assign out_ch.product_sum = to ? '0 : psum;
	assign out_ch.orbit_length = to ? '0 : olen;
endmodule

/* verif/tb_coa_if.sv */
`timescale 1ns / 1ps

// The block's channel interfaces come from the RTL; this file adds the
// APB-style configuration bundle used by the testbench.
interface coa_apb_if (input logic clk);
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
endinterface

/* verif/tb_ca_orbit_correlation_average.sv */
`timescale 1ns / 1ps

module tb_ca_orbit_correlation_average;
	import coa_pkg::*;

	localparam int MAX_CYCLES = 8000000;
	localparam logic [3:0] ADDR_SIDE = 4'd0;
	localparam logic [3:0] ADDR_LIMIT = 4'd4;
	localparam logic [3:0] ADDR_FIRST = 4'd8;
	localparam logic [3:0] ADDR_SECOND = 4'd12;

	typedef struct {
		logic signed [31:0] average_q30;
		logic signed [32:0] product_sum;
		logic [31:0] orbit_length;
		logic timed_out;
	} orbit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	coa_in_if in_if ();
	coa_out_if out_if ();
	coa_apb_if apb (clk);

	ca_orbit_correlation_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if),
		.psel(apb.psel),
		.penable(apb.penable),
		.pwrite(apb.pwrite),
		.paddr(apb.paddr),
		.pwdata(apb.pwdata),
		.prdata(apb.prdata),
		.pready(apb.pready)
	);

	always #10 clk = ~clk;

	logic [2:0] side_reg;
	logic [31:0] limit_reg;
	logic [4:0] first_reg;
	logic [4:0] second_reg;

	orbit_result_t orbit_queue[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int timeouts_seen = 0;
	int unsigned cycles = 0;
	bit no_idle = 0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic logic [49:0] ca_advance(logic [49:0] s, int l);
		logic [49:0] r;
		int i;
		int nb;
		r = '0;
		for (int y = 0; y < l; y++) begin
			for (int x = 0; x < l; x++) begin
				i = x + l * y;
				nb = s[2 * (((x + 1) % l) + l * y)] ^ s[2 * (((x + l - 1) % l) + l * y)]
					^ s[2 * (x + l * ((y + 1) % l))] ^ s[2 * (x + l * ((y + l - 1) % l))];
				r[2 * i] = nb[0] ^ s[2 * i + 1];
				r[2 * i + 1] = s[2 * i];
			end
		end
		return r;
	endfunction

	function automatic orbit_result_t predict_orbit(logic [49:0] start);
		orbit_result_t res;
		int l;
		int n;
		int a;
		int b;
		logic [63:0] mask;
		logic [49:0] tort;
		logic [49:0] hare;
		logic [49:0] s;
		longint unsigned lim;
		longint unsigned power;
		longint unsigned lam;
		longint unsigned mag;
		longint unsigned q;
		longint sum;
		l = side_reg < 2 ? 2 : (side_reg > 5 ? 5 : int'(side_reg));
		n = l * l;
		mask = (64'd1 << (2 * n)) - 64'd1;
		start = start & mask[49:0];
		lim = limit_reg;
		a = first_reg % n;
		b = second_reg % n;
		tort = start;
		hare = ca_advance(start, l);
		power = 1;
		lam = 1;
		while (tort != hare && lam < lim) begin
			if (power == lam) begin
				tort = hare;
				power = power << 1;
				lam = 0;
			end
			hare = ca_advance(hare, l);
			lam++;
		end
		if (tort != hare || lam > lim) begin
			res.average_q30 = '0;
			res.product_sum = '0;
			res.orbit_length = '0;
			res.timed_out = 1'b1;
			return res;
		end
		sum = 0;
		s = start;
		for (longint unsigned k = 0; k < lam; k++) begin
			if (s[2 * a] == s[2 * b]) sum++;
			else sum--;
			s = ca_advance(s, l);
		end
		mag = sum < 0 ? -sum : sum;
		q = (mag << 30) / lam;
		res.average_q30 = sum < 0 ? -q[31:0] : q[31:0];
		res.product_sum = sum[32:0];
		res.orbit_length = lam[31:0];
		res.timed_out = 1'b0;
		return res;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		orbit_result_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				results_seen++;
				if (out_if.timed_out) timeouts_seen++;
				if (orbit_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
				end else begin
					want = orbit_queue.pop_front();
					if (out_if.average_q30 !== want.average_q30
						|| out_if.product_sum !== want.product_sum
						|| out_if.orbit_length !== want.orbit_length
						|| out_if.timed_out !== want.timed_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected avg %0d sum %0d len %0d to %0b, got avg %0d sum %0d len %0d to %0b",
								want.average_q30, want.product_sum, want.orbit_length,
								want.timed_out, out_if.average_q30, out_if.product_sum,
								out_if.orbit_length, out_if.timed_out);
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_state(logic [49:0] st);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.initial_state <= st;
		do @(posedge clk); while (!in_if.ready);
		orbit_queue.push_back(predict_orbit(st));
		items_sent++;
	endtask

	task automatic drain;
		@(posedge clk);
		in_if.valid <= 1'b0;
		wait (orbit_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [31:0] data);
		apb.psel <= 1'b1;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b1;
		apb.paddr <= addr;
		apb.pwdata <= data;
		@(posedge clk);
		apb.penable <= 1'b1;
		do @(posedge clk); while (!apb.pready);
		apb.psel <= 1'b0;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b0;
		case (addr)
			ADDR_SIDE: side_reg = data[2:0];
			ADDR_LIMIT: limit_reg = data;
			ADDR_FIRST: first_reg = data[4:0];
			default: second_reg = data[4:0];
		endcase
	endtask

	task automatic configure(int side, logic [31:0] lim, int fs, int ss);
		write_reg(ADDR_SIDE, side);
		write_reg(ADDR_LIMIT, lim);
		write_reg(ADDR_FIRST, fs);
		write_reg(ADDR_SECOND, ss);
	endtask

	function automatic logic [49:0] random_state();
		logic [49:0] st;
		st = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: st = 50'd1 << $urandom_range(0, 49);
			1: st = st & {$urandom, $urandom};
			default: ;
		endcase
		return st;
	endfunction

	task automatic test_reset_config;
		send_state('0);
		send_state({50{1'b1}});
		send_state(50'h1);
		send_state(50'h2);
		drain();
	endtask

	task automatic test_directed_extremes;
		configure(2, 32'hFFFFFFFF, 0, 3);
		send_state('0);
		send_state({50{1'b1}});
		send_state(50'h55);
		send_state(50'hAA);
		drain();
		configure(2, 1, 1, 2);
		send_state('0);
		send_state(50'h1);
		drain();
		configure(3, 0, 0, 8);
		send_state(50'h3);
		drain();
		configure(0, 50, 31, 30);
		send_state(50'h9);
		drain();
		configure(7, 600, 24, 0);
		send_state({50{1'b1}});
		send_state(50'h1 << 49);
		drain();
		configure(1, 50, 5, 17);
		send_state(50'h6);
		drain();
	endtask

	task automatic test_limit_boundary;
		orbit_result_t r;
		logic [49:0] st;
		configure(3, 5000, 2, 7);
		for (int t = 0; t < 4; t++) begin
			st = random_state();
			r = predict_orbit(st);
			if (!r.timed_out && r.orbit_length > 1) begin
				write_reg(ADDR_LIMIT, r.orbit_length);
				send_state(st);
				drain();
				write_reg(ADDR_LIMIT, r.orbit_length - 1);
				send_state(st);
				drain();
				write_reg(ADDR_LIMIT, 5000);
			end
		end
	endtask

	task automatic test_random_phase(int side, logic [31:0] lim, int count);
		configure(side, lim, $urandom_range(0, 31), $urandom_range(0, 31));
		no_idle = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < count; k++) send_state(random_state());
		drain();
		no_idle = 0;
	endtask

	task automatic test_backpressure;
		configure(2, 100, 0, 1);
		@(negedge clk);
		hold_request = 2000;
		no_idle = 1;
		for (int k = 0; k < 12; k++) send_state(random_state());
		no_idle = 0;
		drain();
	endtask

	initial begin
		in_if.valid = 1'b0;
		in_if.initial_state = '0;
		apb.psel = 1'b0;
		apb.penable = 1'b0;
		apb.pwrite = 1'b0;
		apb.paddr = '0;
		apb.pwdata = '0;
		side_reg = 3'd4;
		limit_reg = 32'd100000000;
		first_reg = 5'd0;
		second_reg = 5'd12;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_directed_extremes();
		test_limit_boundary();
		test_backpressure();
		test_random_phase(2, 64, 350);
		test_random_phase(3, 400, 400);
		test_random_phase(4, 600, 400);
		test_random_phase(5, 500, 350);
		test_random_phase(7, 300, 150);
		test_random_phase(0, 32'hFFFFFFFF, 200);
		test_random_phase(6, 1, 100);

		$display("Sent %0d items and checked %0d results, %0d of them timeouts,",
			items_sent, results_seen, timeouts_seen);
		$display("over torus sides 2 to 5, clamped sides, and limits from 0 to the maximum.");
		if (mismatches == 0 && orbit_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, orbit_queue.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/coa_pkg.sv
rtl/coa_if.sv
rtl/coa_datapath.sv
rtl/coa_ctrl.sv
rtl/ca_orbit_correlation_average.sv
verif/tb_coa_if.sv
verif/tb_ca_orbit_correlation_average.sv
